// ===== hdl/nbpc_pkg.sv =====
package nbpc_pkg;

  localparam int IMAGE_WIDTH = 16;
  localparam int IMAGE_HEIGHT = 16;
  localparam int BIN_LIMIT = 16;
  localparam int COUNT_BITS = 16;

  localparam int PIXELS = IMAGE_WIDTH * IMAGE_HEIGHT;
  localparam int BINS = BIN_LIMIT + 1;
  localparam int DEPTH = PIXELS * BINS;
  localparam int ADDR_W = $clog2(DEPTH);

  localparam int PIX_W = 8;
  localparam int BIN_W = 5;
  localparam int OP_W = 2;
  localparam int IN_DATA_W = 16;
  localparam int OUT_DATA_W = 32;

  localparam int SMOOTH_W = 16;
  localparam logic [SMOOTH_W-1:0] SMOOTH_RESET = 16'd256;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  localparam int LP_W = 16;
  localparam logic signed [LP_W-1:0] LOG_FLOOR = 16'sh8000;
  localparam logic signed [LP_W-1:0] LOG_CEIL = 16'sh7fff;

  localparam int SCORE_W = 24;
  localparam logic signed [SCORE_W-1:0] SCORE_ONE = 24'sd256;
  localparam logic signed [SCORE_W-1:0] SCORE_MAX = 24'sh7fffff;
  localparam logic signed [SCORE_W-1:0] SCORE_MIN = 24'sh800000;

  // log2 unit: operand is count * 256 + smoothing
  localparam int LOG_IN_W = COUNT_BITS + 9;
  localparam int MANT_W = 31;
  localparam int NORM_W = (LOG_IN_W > MANT_W) ? LOG_IN_W : MANT_W;
  localparam int E_W = $clog2(LOG_IN_W);
  localparam int FRAC_W = 16;
  localparam int LOG_W = E_W + FRAC_W;

  localparam int LN2_W = 18;
  localparam logic signed [LN2_W-1:0] LN2_Q16 = 18'sd45426;
  localparam int PROD_W = LOG_W + 1 + LN2_W;
  localparam int ROUND_SHIFT = 24;

  localparam logic [OP_W-1:0] OP_CLEAR = 2'd0;
  localparam logic [OP_W-1:0] OP_TRAIN = 2'd1;
  localparam logic [OP_W-1:0] OP_FINALIZE = 2'd2;
  localparam logic [OP_W-1:0] OP_CLASSIFY = 2'd3;

  typedef struct packed {
    logic capture;
    logic clr_start;
    logic clr_step;
    logic tr_read;
    logic tr_write;
    logic log_start;
    logic log_den;
    logic log_lab;
    logic den_store;
    logic fin_read;
    logic mul;
    logic store;
    logic fin_done;
    logic cl_read;
    logic cl_acc;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic last;
    logic addr_last;
    logic log_done;
    logic out_free;
  } stat_t;

endpackage

// ===== hdl/naive_bayes_pixel_classifier.sv =====
// channel   direction  handshake              payload
// s_*       in         s_tvalid / s_tready    tdata: pixel_index, bin, train_label; tuser: op
//                                             tlast: last
// m_*       out        m_tvalid / m_tready    tdata: best_label, score
// smoothing in         smoothing_we           smoothing_wdata
//
// train: one read-modify-write of the count table per request
// classify: one log-probability table read per request; the result waits in an output register
// clear: one count table word per cycle; the same sweep runs after reset
// finalize: two denominator log2 runs, then per count table word and label a log2 (normalize, 16 squaring steps)
// a full output register holds back only a classify request that ends an image
module naive_bayes_pixel_classifier (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [nbpc_pkg::IN_DATA_W-1:0]  s_tdata,   // pixel_index[7:0], bin[12:8], train_label[13]
  input  logic [nbpc_pkg::OP_W-1:0]       s_tuser,   // op[1:0]
  input  logic                            s_tlast,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [nbpc_pkg::OUT_DATA_W-1:0] m_tdata,   // best_label[0], score[24:1]
  input  logic                            smoothing_we,
  input  logic [nbpc_pkg::SMOOTH_W-1:0]   smoothing_wdata
);
  import nbpc_pkg::*;

  cmd_t cmd;
  stat_t stat;

  nbpc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .cmd      (cmd),
    .stat     (stat)
  );

  nbpc_datapath u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .stat            (stat),
    .s_tdata         (s_tdata),
    .s_tuser         (s_tuser),
    .s_tlast         (s_tlast),
    .smoothing_we    (smoothing_we),
    .smoothing_wdata (smoothing_wdata),
    .m_tvalid        (m_tvalid),
    .m_tready        (m_tready),
    .m_tdata         (m_tdata)
  );

endmodule

// ===== hdl/nbpc_ram.sv =====
module nbpc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hdl/nbpc_log2.sv =====
module nbpc_log2 (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [nbpc_pkg::LOG_IN_W-1:0] x,
  output logic                          busy,
  output logic                          done,
  output logic [nbpc_pkg::LOG_W-1:0]    result
);
  import nbpc_pkg::*;

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_NORM = 2'd1;
  localparam logic [1:0] PH_SQ = 2'd2;

  logic [1:0] phase;
  logic [NORM_W-1:0] nx;
  logic [MANT_W-1:0] m;
  logic [E_W-1:0] e;
  logic [FRAC_W-1:0] frac;
  logic [3:0] cnt;
  logic [2*MANT_W-1:0] sq;
  logic [MANT_W:0] sq_top;

  assign sq = {{MANT_W{1'b0}}, m} * {{MANT_W{1'b0}}, m};
  assign sq_top = sq[2*MANT_W-1:MANT_W-1];
  assign busy = (phase != PH_IDLE);
  assign result = {e, frac};

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      case (phase)
        PH_IDLE: begin
          if (start) begin
            nx <= {x, {(NORM_W - LOG_IN_W){1'b0}}};
            e <= E_W'(LOG_IN_W - 1);
            frac <= '0;
            phase <= PH_NORM;
          end
        end
        PH_NORM: begin
          if (nx[NORM_W-1] || e == '0) begin
            m <= nx[NORM_W-1 -: MANT_W];
            cnt <= '0;
            phase <= PH_SQ;
          end else begin
            nx <= {nx[NORM_W-2:0], 1'b0};
            e <= e - 1'b1;
          end
        end
        PH_SQ: begin
          if (sq_top[MANT_W]) begin
            m <= sq_top[MANT_W:1];
            frac <= {frac[FRAC_W-2:0], 1'b1};
          end else begin
            m <= sq_top[MANT_W-1:0];
            frac <= {frac[FRAC_W-2:0], 1'b0};
          end
          cnt <= cnt + 1'b1;
          if (cnt == 4'd15) begin
            phase <= PH_IDLE;
            done <= 1'b1;
          end
        end
        default: begin
          phase <= PH_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== hdl/nbpc_datapath.sv =====
module nbpc_datapath (
  input  logic                            clk,
  input  logic                            rst,
  input  nbpc_pkg::cmd_t                  cmd,
  output nbpc_pkg::stat_t                 stat,
  input  logic [nbpc_pkg::IN_DATA_W-1:0]  s_tdata,   // pixel_index, bin, train_label
  input  logic [nbpc_pkg::OP_W-1:0]       s_tuser,   // op
  input  logic                            s_tlast,
  input  logic                            smoothing_we,
  input  logic [nbpc_pkg::SMOOTH_W-1:0]   smoothing_wdata,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [nbpc_pkg::OUT_DATA_W-1:0] m_tdata    // best_label, score
);
  import nbpc_pkg::*;

  logic [SMOOTH_W-1:0] smoothing;
  logic [PIX_W-1:0] req_pix;
  logic [BIN_W-1:0] req_bin;
  logic req_lab;
  logic req_last;
  logic [OP_W-1:0] req_op;
  logic req_valid;
  logic [ADDR_W-1:0] off;
  logic [ADDR_W-1:0] addr;
  logic [ADDR_W-1:0] addr_next;
  logic addr_last;
  logic [COUNT_BITS-1:0] img0, img1;
  logic signed [SCORE_W-1:0] score0, score1;
  logic finalized;
  logic [LOG_W-1:0] dlog0, dlog1;
  logic signed [LP_W-1:0] lp0;
  logic signed [PROD_W-1:0] prod;
  logic out_valid;
  logic out_label;
  logic signed [SCORE_W-1:0] out_score;

  logic cnt_we, cnt_re;
  logic [ADDR_W-1:0] cnt_waddr, cnt_raddr;
  logic [2*COUNT_BITS-1:0] cnt_wdata, cnt_rd;
  logic lp_re;
  logic [2*LP_W-1:0] lp_rd;

  logic [COUNT_BITS-1:0] cnt_old, cnt_inc, cnt_sel, img_sel, base;
  logic [LOG_IN_W-1:0] log_x;
  logic log_busy, log_done;
  logic [LOG_W-1:0] log_res, dlog_sel;
  logic signed [LOG_W:0] diff;
  logic signed [PROD_W-1:0] rnd, q;
  logic signed [LP_W-1:0] lp_new;
  logic num_zero, den_zero;
  logic signed [LP_W-1:0] p0, p1;

  function automatic logic signed [SCORE_W-1:0] sat_add(logic signed [SCORE_W-1:0] a,
                                                        logic signed [LP_W-1:0] b);
    logic signed [SCORE_W:0] s;
    s = {a[SCORE_W-1], a} + (SCORE_W + 1)'(b);
    if (s > $signed({SCORE_MAX[SCORE_W-1], SCORE_MAX})) begin
      return SCORE_MAX;
    end else if (s < $signed({SCORE_MIN[SCORE_W-1], SCORE_MIN})) begin
      return SCORE_MIN;
    end
    return s[SCORE_W-1:0];
  endfunction

  assign req_valid = (32'(req_pix) < PIXELS) && (32'(req_bin) < BINS);
  assign off = ADDR_W'(32'(req_pix) * BINS + 32'(req_bin));
  assign addr_last = (32'(addr) == DEPTH - 1);
  assign addr_next = addr_last ? '0 : addr + 1'b1;

  // count table: both labels in one word, label 1 in the upper half
  assign cnt_old = req_lab ? cnt_rd[2*COUNT_BITS-1:COUNT_BITS] : cnt_rd[COUNT_BITS-1:0];
  assign cnt_inc = (cnt_old == COUNT_MAX) ? cnt_old : cnt_old + 1'b1;
  assign cnt_we = cmd.clr_step || (cmd.tr_write && req_valid);
  assign cnt_waddr = cmd.clr_step ? addr : off;
  always_comb begin
    if (cmd.clr_step) begin
      cnt_wdata = '0;
    end else if (req_lab) begin
      cnt_wdata = {cnt_inc, cnt_rd[COUNT_BITS-1:0]};
    end else begin
      cnt_wdata = {cnt_rd[2*COUNT_BITS-1:COUNT_BITS], cnt_inc};
    end
  end
  assign cnt_re = cmd.fin_read || (cmd.tr_read && req_valid);
  assign cnt_raddr = cmd.fin_read ? addr : off;

  nbpc_ram #(.WIDTH(2 * COUNT_BITS), .DEPTH(DEPTH)) u_cnt_ram (
    .clk   (clk),
    .we    (cnt_we),
    .waddr (cnt_waddr),
    .wdata (cnt_wdata),
    .re    (cnt_re),
    .raddr (cnt_raddr),
    .rdata (cnt_rd)
  );

  assign lp_re = cmd.cl_read && req_valid;

  nbpc_ram #(.WIDTH(2 * LP_W), .DEPTH(DEPTH)) u_lp_ram (
    .clk   (clk),
    .we    (cmd.store && cmd.log_lab),
    .waddr (addr),
    .wdata ({lp_new, lp0}),
    .re    (lp_re),
    .raddr (off),
    .rdata (lp_rd)
  );

  // log operand and ratio
  assign cnt_sel = cmd.log_lab ? cnt_rd[2*COUNT_BITS-1:COUNT_BITS] : cnt_rd[COUNT_BITS-1:0];
  assign img_sel = cmd.log_lab ? img1 : img0;
  assign base = cmd.log_den ? img_sel : cnt_sel;
  assign log_x = LOG_IN_W'({base, 8'b0}) + LOG_IN_W'(smoothing);
  assign num_zero = (cnt_sel == '0) && (smoothing == '0);
  assign den_zero = (img_sel == '0) && (smoothing == '0);
  assign dlog_sel = cmd.log_lab ? dlog1 : dlog0;
  assign diff = $signed({1'b0, log_res}) - $signed({1'b0, dlog_sel});
  assign rnd = prod + $signed(PROD_W'(1) <<< (ROUND_SHIFT - 1));
  assign q = rnd >>> ROUND_SHIFT;

  always_comb begin
    if (num_zero || den_zero) begin
      lp_new = LOG_FLOOR;
    end else if (q > PROD_W'(LOG_CEIL)) begin
      lp_new = LOG_CEIL;
    end else if (q < PROD_W'(LOG_FLOOR)) begin
      lp_new = LOG_FLOOR;
    end else begin
      lp_new = q[LP_W-1:0];
    end
  end

  nbpc_log2 u_log2 (
    .clk    (clk),
    .rst    (rst),
    .start  (cmd.log_start),
    .x      (log_x),
    .busy   (log_busy),
    .done   (log_done),
    .result (log_res)
  );

  assign p0 = (req_valid && finalized) ? $signed(lp_rd[LP_W-1:0]) : LOG_FLOOR;
  assign p1 = (req_valid && finalized) ? $signed(lp_rd[2*LP_W-1:LP_W]) : LOG_FLOOR;

  always_ff @(posedge clk) begin
    if (rst) begin
      smoothing <= SMOOTH_RESET;
      addr <= '0;
      img0 <= '0;
      img1 <= '0;
      score0 <= SCORE_ONE;
      score1 <= SCORE_ONE;
      finalized <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (smoothing_we) begin
        smoothing <= smoothing_wdata;
      end
      if (cmd.clr_start) begin
        addr <= '0;
        img0 <= '0;
        img1 <= '0;
        score0 <= SCORE_ONE;
        score1 <= SCORE_ONE;
        finalized <= 1'b0;
      end
      if (cmd.clr_step || (cmd.store && cmd.log_lab)) begin
        addr <= addr_next;
      end
      if (cmd.tr_write && req_last) begin
        if (req_lab && img1 != COUNT_MAX) begin
          img1 <= img1 + 1'b1;
        end else if (!req_lab && img0 != COUNT_MAX) begin
          img0 <= img0 + 1'b1;
        end
      end
      if (cmd.fin_done) begin
        finalized <= 1'b1;
      end
      if (cmd.cl_acc) begin
        score0 <= sat_add(score0, p0);
        score1 <= sat_add(score1, p1);
      end
      if (out_valid && m_tready) begin
        out_valid <= 1'b0;
      end
      if (cmd.emit) begin
        out_valid <= 1'b1;
        score0 <= SCORE_ONE;
        score1 <= SCORE_ONE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_pix <= s_tdata[PIX_W-1:0];
      req_bin <= s_tdata[PIX_W +: BIN_W];
      req_lab <= s_tdata[PIX_W + BIN_W];
      req_last <= s_tlast;
      req_op <= s_tuser;
    end
    if (cmd.den_store) begin
      if (cmd.log_lab) begin
        dlog1 <= log_res;
      end else begin
        dlog0 <= log_res;
      end
    end
    if (cmd.mul) begin
      prod <= PROD_W'(diff * LN2_Q16);
    end
    if (cmd.store && !cmd.log_lab) begin
      lp0 <= lp_new;
    end
    if (cmd.emit) begin
      out_label <= (score1 >= score0);
      out_score <= (score1 >= score0) ? score1 : score0;
    end
  end

  assign stat.op = req_op;
  assign stat.last = req_last;
  assign stat.addr_last = addr_last;
  assign stat.log_done = log_done;
  assign stat.out_free = !out_valid;

  assign m_tvalid = out_valid;
  assign m_tdata = {(OUT_DATA_W - SCORE_W - 1)'(0), out_score, out_label};

`ifndef NO_ASSERTIONS
  a_addr_range: assert property (@(posedge clk) disable iff (rst) 32'(addr) < DEPTH)
    else $error("sweep address out of range");
  a_log_start_idle: assert property (@(posedge clk) disable iff (rst) cmd.log_start |-> !log_busy)
    else $error("log unit started while busy");
  a_emit_free: assert property (@(posedge clk) disable iff (rst) cmd.emit |-> !out_valid)
    else $error("result overwrites pending result");
  a_score_restart: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |=> (score0 == SCORE_ONE) && (score1 == SCORE_ONE))
    else $error("scores not restarted after result");
`endif

endmodule

// ===== hdl/nbpc_ctrl.sv =====
module nbpc_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            s_tvalid,
  output logic            s_tready,
  output nbpc_pkg::cmd_t  cmd,
  input  nbpc_pkg::stat_t stat
);
  import nbpc_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_DECODE = 4'd1;
  localparam logic [3:0] S_CLEAR = 4'd2;
  localparam logic [3:0] S_TR_RD = 4'd3;
  localparam logic [3:0] S_TR_WR = 4'd4;
  localparam logic [3:0] S_FD_START = 4'd5;
  localparam logic [3:0] S_FD_WAIT = 4'd6;
  localparam logic [3:0] S_FN_RD = 4'd7;
  localparam logic [3:0] S_FN_START = 4'd8;
  localparam logic [3:0] S_FN_WAIT = 4'd9;
  localparam logic [3:0] S_FN_MUL = 4'd10;
  localparam logic [3:0] S_FN_STORE = 4'd11;
  localparam logic [3:0] S_CL_RD = 4'd12;
  localparam logic [3:0] S_CL_ACC = 4'd13;
  localparam logic [3:0] S_CL_EMIT = 4'd14;

  logic [3:0] state, state_next;
  logic lab, lab_next;

  assign s_tready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    lab_next = lab;
    cmd = '0;
    cmd.log_lab = lab;
    case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          cmd.capture = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        case (stat.op)
          OP_CLEAR: begin
            cmd.clr_start = 1'b1;
            state_next = S_CLEAR;
          end
          OP_TRAIN: begin
            state_next = S_TR_RD;
          end
          OP_FINALIZE: begin
            lab_next = 1'b0;
            state_next = S_FD_START;
          end
          default: begin
            state_next = S_CL_RD;
          end
        endcase
      end
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (stat.addr_last) begin
          state_next = S_IDLE;
        end
      end
      S_TR_RD: begin
        cmd.tr_read = 1'b1;
        state_next = S_TR_WR;
      end
      S_TR_WR: begin
        cmd.tr_write = 1'b1;
        state_next = S_IDLE;
      end
      S_FD_START: begin
        cmd.log_start = 1'b1;
        cmd.log_den = 1'b1;
        state_next = S_FD_WAIT;
      end
      S_FD_WAIT: begin
        cmd.log_den = 1'b1;
        if (stat.log_done) begin
          cmd.den_store = 1'b1;
          lab_next = !lab;
          state_next = lab ? S_FN_RD : S_FD_START;
        end
      end
      S_FN_RD: begin
        cmd.fin_read = 1'b1;
        state_next = S_FN_START;
      end
      S_FN_START: begin
        cmd.log_start = 1'b1;
        state_next = S_FN_WAIT;
      end
      S_FN_WAIT: begin
        if (stat.log_done) begin
          state_next = S_FN_MUL;
        end
      end
      S_FN_MUL: begin
        cmd.mul = 1'b1;
        state_next = S_FN_STORE;
      end
      S_FN_STORE: begin
        cmd.store = 1'b1;
        lab_next = !lab;
        if (!lab) begin
          state_next = S_FN_START;
        end else if (stat.addr_last) begin
          cmd.fin_done = 1'b1;
          state_next = S_IDLE;
        end else begin
          state_next = S_FN_RD;
        end
      end
      S_CL_RD: begin
        cmd.cl_read = 1'b1;
        state_next = S_CL_ACC;
      end
      S_CL_ACC: begin
        cmd.cl_acc = 1'b1;
        state_next = stat.last ? S_CL_EMIT : S_IDLE;
      end
      S_CL_EMIT: begin
        if (stat.out_free) begin
          cmd.emit = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      lab <= 1'b0;
    end else begin
      state <= state_next;
      lab <= lab_next;
    end
  end

endmodule

// ===== sim/bayes_checker.sv =====
module bayes_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  input  logic                            s_tready,
  input  logic [nbpc_pkg::IN_DATA_W-1:0]  s_tdata,
  input  logic [nbpc_pkg::OP_W-1:0]       s_tuser,
  input  logic                            s_tlast,
  input  logic                            m_tvalid,
  input  logic                            m_tready,
  input  logic [nbpc_pkg::OUT_DATA_W-1:0] m_tdata,
  input  logic                            smoothing_we,
  input  logic [nbpc_pkg::SMOOTH_W-1:0]   smoothing_wdata,
  output int                              failures,
  output int                              pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import nbpc_pkg::*;

  typedef struct {
    logic                      best;
    logic signed [SCORE_W-1:0] score;
  } verdict_t;

  int unsigned               feat_cnt[2][DEPTH];
  logic signed [LP_W-1:0]    log_prob[2][DEPTH];
  int unsigned               img_cnt[2];
  int                        class_score[2];
  longint unsigned           smooth;
  verdict_t                  predicted_verdicts[$];

  function automatic longint log2_fix(longint unsigned x);
    int e;
    longint unsigned m;
    longint f;
    e = 63;
    f = 0;
    while (e > 0 && x[e] == 1'b0) e--;
    if (e >= 30) m = x >> (e - 30);
    else m = x << (30 - e);
    for (int i = 0; i < 16; i++) begin
      m = (m * m) >> 30;
      f = f << 1;
      if (m >= (64'd2 << 30)) begin
        m = m >> 1;
        f = f | 1;
      end
    end
    return longint'(e) * 65536 + f;
  endfunction

  function automatic logic signed [LP_W-1:0] log_ratio(int unsigned cnt, int unsigned imgs);
    longint unsigned num;
    longint unsigned den;
    longint q;
    num = longint'(cnt) * 256 + smooth;
    den = longint'(imgs) * 256 + smooth;
    if (num == 0 || den == 0) return LOG_FLOOR;
    q = ((log2_fix(num) - log2_fix(den)) * 45426 + (64'sd1 << 23)) >>> 24;
    if (q > 32767) q = 32767;
    if (q < -32768) q = -32768;
    return q[LP_W-1:0];
  endfunction

  function automatic int sat_score(int a, int b);
    longint s;
    s = longint'(a) + b;
    if (s > 8388607) s = 8388607;
    if (s < -8388608) s = -8388608;
    return int'(s);
  endfunction

  task automatic clear_tables();
    for (int l = 0; l < 2; l++) begin
      for (int i = 0; i < DEPTH; i++) begin
        feat_cnt[l][i] = 0;
        log_prob[l][i] = LOG_FLOOR;
      end
      img_cnt[l] = 0;
      class_score[l] = 256;
    end
  endtask

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
    failures++;
  endtask

  task automatic bayes_step();
    logic [OP_W-1:0] op;
    int pix;
    int bin;
    int lab;
    int off;
    bit ok;
    verdict_t v;
    op = s_tuser;
    pix = s_tdata[7:0];
    bin = s_tdata[12:8];
    lab = s_tdata[13];
    ok = pix < PIXELS && bin < BINS;
    off = pix * BINS + bin;
    case (op)
      OP_CLEAR: clear_tables();
      OP_TRAIN: begin
        if (ok && feat_cnt[lab][off] < 65535) feat_cnt[lab][off]++;
        if (s_tlast && img_cnt[lab] < 65535) img_cnt[lab]++;
      end
      OP_FINALIZE: begin
        for (int l = 0; l < 2; l++)
          for (int i = 0; i < DEPTH; i++)
            log_prob[l][i] = log_ratio(feat_cnt[l][i], img_cnt[l]);
      end
      default: begin
        for (int l = 0; l < 2; l++)
          class_score[l] = sat_score(class_score[l], ok ? int'(log_prob[l][off]) : -32768);
        if (s_tlast) begin
          v.best = class_score[1] >= class_score[0];
          v.score = SCORE_W'(class_score[v.best]);
          predicted_verdicts.push_back(v);
          class_score[0] = 256;
          class_score[1] = 256;
        end
      end
    endcase
  endtask

  initial begin
    failures = 0;
    pending = 0;
    smooth = SMOOTH_RESET;
  end

  always @(posedge clk) begin
    verdict_t want;
    if (rst) begin
      smooth = SMOOTH_RESET;
      clear_tables();
      predicted_verdicts.delete();
    end else begin
      if (smoothing_we) smooth = smoothing_wdata;
      if (m_tvalid && m_tready) begin
        if (predicted_verdicts.size() == 0) begin
          report_mismatch("unexpected result", m_tdata, 0);
        end else begin
          want = predicted_verdicts.pop_front();
          if (m_tdata[0] !== want.best) report_mismatch("best_label", m_tdata[0], want.best);
          if ($signed(m_tdata[24:1]) !== want.score)
            report_mismatch("score", $signed(m_tdata[24:1]), want.score);
        end
      end
      if (s_tvalid && s_tready) bayes_step();
    end
    pending <= predicted_verdicts.size();
  end
endmodule

// ===== sim/testbench.sv =====
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import nbpc_pkg::*;

  logic                  clk;
  logic                  rst;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata;
  logic [OP_W-1:0]       s_tuser;
  logic                  s_tlast;
  logic                  m_tvalid;
  logic                  m_tready;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic                  smoothing_we;
  logic [SMOOTH_W-1:0]   smoothing_wdata;
  int                    failures;
  int                    pending;
  int                    hold_left;
  int                    burst_left;

  naive_bayes_pixel_classifier dut (.*);

  bayes_checker checker_i (.*);

  always #5 clk = ~clk;

  initial begin
    #100ms;
    $display("FAILURE");
    $finish;
  end

  // receiver stall pattern
  initial begin
    int win;
    int mode;
    win = 0;
    mode = 0;
    m_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        if (win == 0) begin
          win = $urandom_range(8, 64);
          mode = $urandom_range(0, 2);
        end
        win--;
        case (mode)
          0: m_tready <= 1'b1;
          1: m_tready <= 1'($urandom_range(0, 1));
          default: m_tready <= ($urandom_range(0, 4) == 0);
        endcase
      end
    end
  end

  task automatic send_req(logic [OP_W-1:0] op, int pix, int bin, bit lab, bit last);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 30);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    s_tvalid <= 1'b1;
    s_tuser <= op;
    s_tlast <= last;
    s_tdata <= {2'b00, lab, bin[4:0], pix[7:0]};
    do @(posedge clk); while (!s_tready);
    burst_left--;
  endtask

  task automatic wait_idle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0 || !s_tready) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_smoothing(int v);
    smoothing_we <= 1'b1;
    smoothing_wdata <= v[SMOOTH_W-1:0];
    @(posedge clk);
    smoothing_we <= 1'b0;
  endtask

  function automatic int pick_pix();
    return ($urandom_range(0, 4) != 0) ? $urandom_range(0, 7) : $urandom_range(0, 255);
  endfunction

  function automatic int pick_bin();
    return ($urandom_range(0, 9) != 0) ? $urandom_range(0, 3) : $urandom_range(0, 31);
  endfunction

  task automatic run_phase(int train_n, int class_n, bit do_fin, bit long_img);
    int done;
    int n;
    bit lab;
    send_req(OP_CLEAR, $urandom_range(0, 255), $urandom_range(0, 31),
             1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    done = 0;
    while (done < train_n) begin
      n = $urandom_range(1, 10);
      lab = 1'($urandom_range(0, 1));
      for (int i = 0; i < n; i++) send_req(OP_TRAIN, pick_pix(), pick_bin(), lab, i == n - 1);
      if ($urandom_range(0, 9) == 0) send_req(OP_TRAIN, pick_pix(), pick_bin(), lab, 1'b0);
      done += n;
    end
    if (do_fin) send_req(OP_FINALIZE, pick_pix(), pick_bin(), 1'($urandom_range(0, 1)), 1'b0);
    if (long_img) begin
      for (int i = 0; i < 300; i++)
        send_req(OP_CLASSIFY, pick_pix(), $urandom_range(17, 31), 1'b0, i == 299);
    end
    // long receiver hold while one-pixel images pile up
    hold_left = 300;
    for (int i = 0; i < 8; i++) send_req(OP_CLASSIFY, pick_pix(), pick_bin(), 1'b0, 1'b1);
    done = 0;
    while (done < class_n) begin
      n = $urandom_range(1, 12);
      for (int i = 0; i < n; i++)
        send_req(OP_CLASSIFY, pick_pix(), pick_bin(), 1'($urandom_range(0, 1)), i == n - 1);
      done += n;
    end
    wait_idle();
  endtask

  initial begin
    clk = 1'b0;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = OP_CLEAR;
    s_tlast = 1'b0;
    smoothing_we = 1'b0;
    smoothing_wdata = '0;
    hold_left = 0;
    burst_left = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    write_smoothing(0);

    // directed
    send_req(OP_CLASSIFY, 0, 0, 1'b0, 1'b1);
    send_req(OP_CLASSIFY, 255, 31, 1'b1, 1'b0);
    send_req(OP_CLASSIFY, 255, 16, 1'b0, 1'b1);
    send_req(OP_TRAIN, 0, 0, 1'b0, 1'b0);
    send_req(OP_TRAIN, 255, 16, 1'b1, 1'b1);
    send_req(OP_TRAIN, 255, 31, 1'b1, 1'b1);
    send_req(OP_TRAIN, 0, 17, 1'b0, 1'b0);
    send_req(OP_TRAIN, 0, 0, 1'b0, 1'b1);
    send_req(OP_TRAIN, 3, 5, 1'b0, 1'b0);
    send_req(OP_TRAIN, 3, 5, 1'b0, 1'b0);
    send_req(OP_FINALIZE, 0, 0, 1'b0, 1'b0);
    send_req(OP_CLASSIFY, 0, 0, 1'b0, 1'b0);
    send_req(OP_CLASSIFY, 255, 16, 1'b0, 1'b1);
    send_req(OP_CLASSIFY, 3, 5, 1'b0, 1'b1);
    send_req(OP_CLASSIFY, 7, 2, 1'b0, 1'b1);
    send_req(OP_CLASSIFY, 0, 31, 1'b0, 1'b1);
    send_req(OP_CLASSIFY, 255, 16, 1'b0, 1'b0);
    send_req(OP_CLEAR, 255, 31, 1'b1, 1'b1);
    send_req(OP_CLASSIFY, 255, 16, 1'b1, 1'b1);
    wait_idle();

    write_smoothing(65535);
    run_phase(250, 200, 1'b1, 1'b1);
    write_smoothing($urandom_range(1, 1024));
    run_phase(250, 200, 1'b1, 1'b0);
    write_smoothing(1);
    run_phase(120, 100, 1'b0, 1'b0);

    if (failures == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule
